/* hw/rtl/smpq_pkg.sv */
// types and constants shared by the sorted min priority queue
`default_nettype none

package smpq_pkg;

   localparam int KEY_W   = 32;
   localparam int TAG_W   = 16;
   localparam int COUNT_W = 5;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   // broadcast from the control to every cell
   typedef struct packed {
      logic              en;
      op_type            op;
      logic [KEY_W-1:0]  key;
      logic [TAG_W-1:0]  tag;
   } smpq_cmd_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic              valid;
      logic              place;
      logic [KEY_W-1:0]  key;
      logic [TAG_W-1:0]  tag;
   } smpq_link_type;

endpackage

`default_nettype wire

/* hw/rtl/smpq_if.sv */
// request and response channel interfaces of the priority queue
`default_nettype none

interface smpq_req_if;
   import smpq_pkg::*;
   logic              valid;
   logic              ready;
   logic              op;
   logic [KEY_W-1:0]  key_in;
   logic [TAG_W-1:0]  tag_in;

   modport source (output valid, output op, output key_in, output tag_in, input ready);
   modport sink   (input valid, input op, input key_in, input tag_in, output ready);
endinterface

interface smpq_rsp_if;
   import smpq_pkg::*;
   logic                valid;
   logic                ready;
   logic                ok;
   logic [KEY_W-1:0]    key_out;
   logic [TAG_W-1:0]    tag_out;
   logic [COUNT_W-1:0]  count;
   logic                is_empty;
   logic                is_full;

   modport source (output valid, output ok, output key_out, output tag_out,
                   output count, output is_empty, output is_full, input ready);
   modport sink   (input valid, input ok, input key_out, input tag_out,
                   input count, input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

/* hw/rtl/smpq_cell.sv */
// one slot of the sorted chain: holds an entry and trades with its neighbors
`default_nettype none

module smpq_cell
   import smpq_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire smpq_cmd_type   cmd,
   input  wire smpq_link_type  left_link,
   input  wire smpq_link_type  right_link,
   output smpq_link_type       link
);

   logic              valid_ff, valid_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic              place;

   // new entry belongs at or before this slot
   assign place = !valid_ff || (cmd.key < key_ff);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      tag_in   = tag_ff;
      if (cmd.en) begin
         case (cmd.op)
            OP_INSERT: begin
               valid_in = valid_ff | left_link.valid;
               if (place) begin
                  if (left_link.place) begin
                     key_in = left_link.key;
                     tag_in = left_link.tag;
                  end else begin
                     key_in = cmd.key;
                     tag_in = cmd.tag;
                  end
               end
            end
            OP_REMOVE: begin
               valid_in = right_link.valid;
               key_in   = right_link.key;
               tag_in   = right_link.tag;
            end
            default: begin
               valid_in = valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

   assign link.valid = valid_ff;
   assign link.place = place;
   assign link.key   = key_ff;
   assign link.tag   = tag_ff;

endmodule

`default_nettype wire

/* hw/rtl/sorted_min_priority_queue.sv */
// top level of the sorted min priority queue built as a chain of cells
//
//   channel   dir   beat carries
//   req_bus   in    op, key_in, tag_in
//   rsp_bus   out   ok, key_out, tag_out, count, is_empty, is_full
//
// a request is captured, then fires: every cell shifts or holds in parallel,
// the response register loads, and only then is the next request taken.
// the response register holds a stalled beat while the next request is taken;
// a captured request waits until that register is free.
// reset clears the cell valid bits, the count and both handshakes; the key and
// tag slots are not cleared and no clearing pass runs.
`default_nettype none

module sorted_min_priority_queue
   import smpq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   smpq_req_if.sink   req_bus,
   smpq_rsp_if.source rsp_bus
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic              busy_ff, busy_in;
   op_type            op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                ok_ff, ok_in;
   logic [KEY_W-1:0]    key_out_ff, key_out_in;
   logic [TAG_W-1:0]    tag_out_ff, tag_out_in;
   logic [COUNT_W-1:0]  count_out_ff, count_out_in;
   logic                empty_ff, empty_in;
   logic                full_ff, full_in;

   logic          accept, fire, op_ok, is_full_now, is_empty_now;
   smpq_cmd_type  cmd;
   smpq_link_type link_w [CAPACITY];
   logic [CAPACITY-1:0] valid_vec;

   assign req_bus.ready = !busy_ff;
   assign accept        = req_bus.valid && !busy_ff;
   assign fire          = busy_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign is_full_now   = (count_ff == CNT_W'(CAPACITY));
   assign is_empty_now  = (count_ff == '0);
   assign op_ok         = (op_ff == OP_INSERT) ? !is_full_now : !is_empty_now;

   assign cmd.en  = fire && op_ok;
   assign cmd.op  = op_ff;
   assign cmd.key = key_ff;
   assign cmd.tag = tag_ff;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         smpq_link_type left_w, right_w;
         if (gi == 0) begin : g_head
            assign left_w.valid = 1'b1;
            assign left_w.place = 1'b0;
            assign left_w.key   = key_ff;
            assign left_w.tag   = tag_ff;
         end else begin : g_mid
            assign left_w = link_w[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_tail
            assign right_w.valid = 1'b0;
            assign right_w.place = 1'b0;
            assign right_w.key   = link_w[gi].key;
            assign right_w.tag   = link_w[gi].tag;
         end else begin : g_body
            assign right_w = link_w[gi+1];
         end
         smpq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .left_link  (left_w),
            .right_link (right_w),
            .link       (link_w[gi])
         );
         assign valid_vec[gi] = link_w[gi].valid;
      end
   endgenerate

   // request capture
   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      key_in  = key_ff;
      tag_in  = tag_ff;
      if (accept) begin
         busy_in = 1'b1;
         op_in   = op_type'(req_bus.op);
         key_in  = req_bus.key_in;
         tag_in  = req_bus.tag_in;
      end else if (fire) begin
         busy_in = 1'b0;
      end
   end

   // count and response register
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      ok_in        = ok_ff;
      key_out_in   = key_out_ff;
      tag_out_in   = tag_out_ff;
      count_out_in = count_out_ff;
      empty_in     = empty_ff;
      full_in      = full_ff;
      if (fire) begin
         if (op_ok) begin
            count_in = (op_ff == OP_INSERT) ? count_ff + 1'b1 : count_ff - 1'b1;
         end
         rsp_valid_in = 1'b1;
         ok_in        = op_ok;
         key_out_in   = (op_ok && op_ff == OP_REMOVE) ? link_w[0].key : '0;
         tag_out_in   = (op_ok && op_ff == OP_REMOVE) ? link_w[0].tag : '0;
         count_out_in = COUNT_W'({{COUNT_W{1'b0}}, count_in});
         empty_in     = (count_in == '0);
         full_in      = (count_in == CNT_W'(CAPACITY));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      tag_ff       <= tag_in;
      ok_ff        <= ok_in;
      key_out_ff   <= key_out_in;
      tag_out_ff   <= tag_out_in;
      count_out_ff <= count_out_in;
      empty_ff     <= empty_in;
      full_ff      <= full_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.ok       = ok_ff;
   assign rsp_bus.key_out  = key_out_ff;
   assign rsp_bus.tag_out  = tag_out_ff;
   assign rsp_bus.count    = count_out_ff;
   assign rsp_bus.is_empty = empty_ff;
   assign rsp_bus.is_full  = full_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_valid_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == count_ff)
      else $error("occupied cells disagree with count");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      link_w[1].valid |-> !(link_w[1].key < link_w[0].key))
      else $error("front cells out of order");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.en && op_ff == OP_INSERT) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow count");

   a_no_lost_rsp: assert property (@(posedge clock) disable iff (reset)
      (fire && rsp_valid_ff) |-> rsp_bus.ready)
      else $error("response overwritten while stalled");

endmodule

`default_nettype wire
